// ===== sv/ctts_pkg.sv =====
package ctts_pkg;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;
  localparam logic [1:0] OP_DISP = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_RUN       = 3'd3;
  localparam logic [2:0] ST_NONE      = 3'd4;

  localparam int MAX_RESULTS = 8;
  localparam int NW = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [7:0]  tag;
    logic [15:0] cd;
    logic [15:0] per;
    logic [7:0]  pend;
  } slot_ent_t;

endpackage

// ===== sv/ctts_div.sv =====
module ctts_div #(
  parameter int TICK_MS = 10
) (
  input  logic        clk,
  input  logic [15:0] x,
  output logic [15:0] q
);

  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / TICK_MS);
  localparam int PW = 16 + $clog2(TICK_MS + 1);

  logic [48:0] prod;
  logic [15:0] x_d;
  logic [15:0] q0;
  logic [PW-1:0] qt;
  logic [PW-1:0] r;

  // Stage 1: reciprocal multiply gives the quotient or one less
  always_ff @(posedge clk) begin
    prod <= 49'(x) * 49'(RECIP);
    x_d  <= x;
  end

  assign q0 = prod[47:32];
  assign qt = PW'(q0) * PW'(TICK_MS);
  assign r  = PW'(x_d) - qt;

  // Stage 2: correct by one where the remainder reaches the divisor
  always_ff @(posedge clk) begin
    q <= (r >= PW'(TICK_MS)) ? 16'(q0 + 16'd1) : q0;
  end

endmodule

// ===== sv/cooperative_task_tick_scheduler_top.sv =====
// Tick, delete and dispatch walk the slot memory one slot per cycle while the result output
// does not stall the walk. Add runs a two-stage divide by TICK_MS. A new input is taken only once the last is done.
// Delete ends early at the first match; dispatch ends after its eighth run result.
// Synchronous active-high rst clears all slot used bits, the sequencer and the
// output valid flag; slot memory contents need no clearing.
module cooperative_task_tick_scheduler_top
  import ctts_pkg::*;
#(
  parameter int SLOTS   = 8,
  parameter int TICK_MS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  task_tag,
  input  logic [15:0] delay_ms,
  input  logic [15:0] period_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [7:0]  run_tag,
  output logic [2:0]  slot_index,
  output logic        last
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_FIN  = 3'd2;
  localparam logic [2:0] S_ADD1 = 3'd3;
  localparam logic [2:0] S_ADD2 = 3'd4;
  localparam logic [2:0] S_ADD3 = 3'd5;

  logic [2:0]  state;
  logic [1:0]  op_q;
  logic [7:0]  tag_q;
  logic [15:0] delay_q;
  logic [15:0] period_q;
  logic [15:0] dq;
  logic [15:0] pq;

  logic [SLOTS-1:0] used;
  slot_ent_t        mem [SLOTS];
  slot_ent_t        rd_q;

  logic [CW-1:0] rd_cnt;
  logic [IW-1:0] b_slot;
  logic          b_valid;
  logic [NW-1:0] disp_n;

  logic          hold_valid;
  logic [7:0]    hold_tag;
  logic [IW-1:0] hold_slot;

  logic          out_free;
  logic          issue;
  logic          accept;

  // stage B decisions
  slot_ent_t ent;
  slot_ent_t b_wd;
  logic      b_write;
  logic      b_free;
  logic      b_stall;
  logic      b_hold;
  logic      b_end;
  logic      b_to_fin;

  logic          emit;
  logic [2:0]    e_status;
  logic [7:0]    e_tag;
  logic [IW-1:0] e_slot;
  logic          e_last;

  logic          free_found;
  logic [IW-1:0] free_idx;
  logic          add_set;
  logic          fin_go;

  logic          mem_we;
  logic [IW-1:0] wa;
  slot_ent_t     wd;

  ctts_div #(.TICK_MS(TICK_MS)) u_div_delay (.clk(clk), .x(delay_q), .q(dq));
  ctts_div #(.TICK_MS(TICK_MS)) u_div_period (.clk(clk), .x(period_q), .q(pq));

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  // stage B: modify the entry held in the read register rd_q
  always_comb begin
    ent      = used[b_slot] ? rd_q : '0;
    b_wd     = ent;
    b_write  = 1'b0;
    b_free   = 1'b0;
    b_stall  = 1'b0;
    b_hold   = 1'b0;
    b_end    = 1'b0;
    b_to_fin = 1'b0;
    emit     = 1'b0;
    e_status = ST_OK;
    e_tag    = '0;
    e_slot   = '0;
    e_last   = 1'b1;
    fin_go   = 1'b0;
    add_set  = 1'b0;
    if (state == S_SCAN && b_valid) begin
      unique case (op_q)
        OP_TICK: begin
          if (used[b_slot]) begin
            b_write = 1'b1;
            if (ent.cd == 16'd0) begin
              if (ent.pend != 8'hFF) b_wd.pend = ent.pend + 8'd1;
              b_wd.cd = ent.per;
            end else begin
              b_wd.cd = ent.cd - 16'd1;
            end
          end
        end
        OP_DEL: begin
          if (used[b_slot] && ent.tag == tag_q) begin
            b_stall = !out_free;
            if (out_free) begin
              emit     = 1'b1;
              e_status = ST_OK;
              e_tag    = tag_q;
              e_slot   = b_slot;
              b_free   = 1'b1;
              b_end    = 1'b1;
            end
          end
        end
        OP_DISP: begin
          if (ent.pend != 8'd0) begin
            b_stall = hold_valid && !out_free;
            if (!b_stall) begin
              // push out the previous run now that another follows
              emit     = hold_valid;
              e_status = ST_RUN;
              e_tag    = hold_tag;
              e_slot   = hold_slot;
              e_last   = 1'b0;
              b_hold   = 1'b1;
              if (ent.per == 16'd0) begin
                b_free = 1'b1;
              end else begin
                b_write   = 1'b1;
                b_wd.pend = ent.pend - 8'd1;
              end
              b_to_fin = (disp_n == NW'(MAX_RESULTS - 1));
            end
          end
        end
        OP_ADD: begin
        end
      endcase
    end else if (state == S_FIN) begin
      fin_go = out_free;
      emit   = out_free;
      unique case (op_q)
        OP_TICK: e_status = ST_OK;
        OP_DEL: begin
          e_status = ST_NOT_FOUND;
          e_tag    = tag_q;
        end
        OP_DISP: begin
          e_status = hold_valid ? ST_RUN : ST_NONE;
          e_tag    = hold_valid ? hold_tag : 8'd0;
          e_slot   = hold_valid ? hold_slot : '0;
        end
        OP_ADD: e_status = ST_OK;
      endcase
    end else if (state == S_ADD3) begin
      emit     = out_free;
      fin_go   = out_free;
      add_set  = out_free && free_found;
      e_status = free_found ? ST_OK : ST_FULL;
      e_tag    = tag_q;
      e_slot   = free_found ? free_idx : '0;
    end
  end

  assign issue = (state == S_SCAN) && (rd_cnt < CW'(SLOTS)) && !b_stall &&
                 !b_end && !b_to_fin;

  assign mem_we = b_write || add_set;
  assign wa     = add_set ? free_idx : b_slot;
  always_comb begin
    wd = b_wd;
    if (add_set) begin
      wd.tag  = tag_q;
      wd.cd   = dq;
      wd.per  = pq;
      wd.pend = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wa] <= wd;
    if (issue) rd_q <= mem[rd_cnt[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= opcode;
      tag_q    <= task_tag;
      delay_q  <= delay_ms;
      period_q <= period_ms;
    end
    if (issue) b_slot <= rd_cnt[IW-1:0];
    if (b_hold) begin
      hold_tag  <= ent.tag;
      hold_slot <= b_slot;
    end
    if (emit) begin
      status     <= e_status;
      run_tag    <= e_tag;
      slot_index <= 3'(e_slot);
      last       <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used       <= '0;
      rd_cnt     <= '0;
      b_valid    <= 1'b0;
      disp_n     <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      if (b_free) used[b_slot] <= 1'b0;
      if (add_set) used[free_idx] <= 1'b1;

      if (issue) rd_cnt <= rd_cnt + CW'(1);

      if (issue) b_valid <= 1'b1;
      else if (!b_stall) b_valid <= 1'b0;

      if (b_hold) begin
        hold_valid <= 1'b1;
        disp_n     <= disp_n + NW'(1);
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            rd_cnt     <= '0;
            disp_n     <= '0;
            hold_valid <= 1'b0;
            state      <= (opcode == OP_ADD) ? S_ADD1 : S_SCAN;
          end
        end
        S_SCAN: begin
          if (b_end) begin
            state <= S_IDLE;
          end else if (b_to_fin) begin
            state <= S_FIN;
          end else if (rd_cnt == CW'(SLOTS) && !b_valid) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            state      <= S_IDLE;
            hold_valid <= 1'b0;
          end
        end
        S_ADD1: state <= S_ADD2;
        S_ADD2: state <= S_ADD3;
        S_ADD3: if (fin_go) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || out_ready))
    else $error("result emitted over an untaken result");

  a_bvalid_scan: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (state == S_SCAN))
    else $error("read stage busy outside a scan");

  a_hold_disp: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> (op_q == OP_DISP && state != S_IDLE))
    else $error("held run outside dispatch");

  a_disp_limit: assert property (@(posedge clk) disable iff (rst)
    disp_n <= NW'(MAX_RESULTS))
    else $error("dispatch exceeded result limit");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(b_write && add_set))
    else $error("two slot writes in one cycle");

endmodule
